// File: rtl/rc4_stream_cipher_top_macros.svh
// Assertion macros for the RC4 cipher engine.
// Used by rc4_stream_cipher_top.sv; expects clk and rst_n in scope.
`ifndef RC4_STREAM_CIPHER_TOP_MACROS_SVH
`define RC4_STREAM_CIPHER_TOP_MACROS_SVH

// Same-cycle implication.
`define RC4_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rc4_pkg.sv
// Package for the RC4 cipher engine: request/response types and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int unsigned TABLE_SIZE = 256;
    localparam logic        FUNC_KEY   = 1'b0;
    localparam logic        FUNC_DATA  = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] in_byte;
        logic       last;
    } rc4_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       setup_done;
        logic       last_out;
    } rc4_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D_RD_J,
        ST_D_SWAP,
        ST_D_OUT,
        ST_K_RD_N,
        ST_K_RD_A,
        ST_K_WR_N,
        ST_K_WR_A,
        ST_K_DONE
    } rc4_state_t;

endpackage

// File: rtl/rc4_stream_cipher_top.sv
// RC4 cipher engine top level: sequencer, permutation table, key store.
// Depends on rc4_pkg and rc4_stream_cipher_top_macros.svh.
`timescale 1ns / 1ps

// RC4 engine. Send key bytes (func = 0) master key first, then salt; the byte
// flagged last starts key scheduling, which answers with one setup_done
// response. Data bytes (func = 1) come back XORed with the keystream; the same
// request decrypts. A key byte without last is taken without stalling; a last
// key byte runs 256 mixing steps, each of which makes two dependent reads and
// two writes on the table, one access per cycle. A data byte steps through the
// dependent table accesses in order: read S[i], read S[j], write S[i] while
// reading the keystream entry, write S[j]. req_stall is high while an item is
// in flight; a stalled response slot holds the engine in its final step.
// The table comes out of reset as the identity through per-entry valid bits,
// so there is no clearing pass; key bytes beyond KEY_MAX are dropped.
module rc4_stream_cipher_top
    import rc4_pkg::*;
#(
    parameter int unsigned KEY_MAX = 512
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  rc4_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output rc4_rsp_t rsp
);

`include "rc4_stream_cipher_top_macros.svh"

    localparam int unsigned KIW = $clog2(KEY_MAX);      // key store index
    localparam int unsigned KCW = $clog2(KEY_MAX + 1);  // key count

    // ---------------- state ----------------
    rc4_state_t state_reg, state_next;
    logic [7:0] i_reg, i_next;            // generator i, or schedule step n
    logic [7:0] j_reg, j_next;            // generator j, or schedule accumulator
    logic [7:0] si_reg, si_next;          // S[i] (or S[n]) held for the swap
    logic [7:0] sj_reg, sj_next;
    logic [KCW-1:0] key_count_reg, key_count_next;
    logic [KCW-1:0] kp_reg, kp_next;      // cyclic key pointer
    logic [7:0] byte_reg;
    logic       last_reg;

    // ---------------- permutation table ----------------
    logic [7:0] perm_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] pvalid_reg;    // entry written since last identity
    logic       p_re, p_we, clr_valid;
    logic [7:0] p_raddr, p_waddr, p_wdata;
    logic [7:0] p_rd_reg, p_rda_reg;
    logic       p_rdv_reg;
    logic [7:0] p_rdata;

    // ---------------- key store ----------------
    logic [7:0] key_mem [KEY_MAX];
    logic       k_we, k_re;
    logic [7:0] key_rd_reg;

    // ---------------- response register ----------------
    logic       rsp_valid_reg;
    rc4_rsp_t   rsp_reg, rsp_data;
    logic       rsp_load, rsp_free;

    logic       req_accept;
    logic [7:0] ks;
    logic [7:0] ks_addr;
    logic [7:0] acc_sum;
    logic [KCW-1:0] kp_inc;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    // Unwritten entries read as their own index (identity table).
    assign p_rdata = p_rdv_reg ? p_rd_reg : p_rda_reg;

    // Keystream entry with forwarding of the two swap writes.
    assign ks_addr = si_reg + sj_reg;
    always_comb
    begin
        if (ks_addr == j_reg)
            ks = si_reg;
        else if (ks_addr == i_reg)
            ks = sj_reg;
        else
            ks = p_rdata;
    end

    assign acc_sum = j_reg + p_rdata + key_rd_reg;
    assign kp_inc  = kp_reg + KCW'(1);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        key_count_next = key_count_reg;
        kp_next        = kp_reg;
        p_re           = 1'b0;
        p_raddr        = i_reg;
        p_we           = 1'b0;
        p_waddr        = i_reg;
        p_wdata        = si_reg;
        k_we           = 1'b0;
        k_re           = 1'b0;
        clr_valid      = 1'b0;
        rsp_load       = 1'b0;
        rsp_data       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (req.func == FUNC_DATA)
                    begin
                        i_next     = i_reg + 8'd1;
                        p_re       = 1'b1;
                        p_raddr    = i_reg + 8'd1;
                        state_next = ST_D_RD_J;
                    end
                    else
                    begin
                        if (key_count_reg < KCW'(KEY_MAX))
                        begin
                            k_we           = 1'b1;
                            key_count_next = key_count_reg + KCW'(1);
                        end
                        if (req.last)
                        begin
                            // back to identity, then 256 mixing steps
                            clr_valid  = 1'b1;
                            i_next     = '0;
                            j_next     = '0;
                            kp_next    = '0;
                            state_next = ST_K_RD_N;
                        end
                    end
                end
            end

            // data: S[i] arrives, read S[j + S[i]]
            ST_D_RD_J:
            begin
                j_next     = j_reg + p_rdata;
                si_next    = p_rdata;
                p_re       = 1'b1;
                p_raddr    = j_reg + p_rdata;
                state_next = ST_D_SWAP;
            end

            // data: S[j] arrives, write S[i], read keystream entry
            ST_D_SWAP:
            begin
                sj_next    = p_rdata;
                p_we       = 1'b1;
                p_waddr    = i_reg;
                p_wdata    = p_rdata;
                p_re       = 1'b1;
                p_raddr    = si_reg + p_rdata;
                state_next = ST_D_OUT;
            end

            // data: write S[j]; hold here until the response slot frees
            ST_D_OUT:
            begin
                p_we    = 1'b1;
                p_waddr = j_reg;
                p_wdata = si_reg;
                if (rsp_free)
                begin
                    rsp_load            = 1'b1;
                    rsp_data.out_byte   = byte_reg ^ ks;
                    rsp_data.setup_done = 1'b0;
                    rsp_data.last_out   = last_reg;
                    state_next          = ST_IDLE;
                end
            end

            ST_K_RD_N:
            begin
                p_re       = 1'b1;
                p_raddr    = i_reg;
                k_re       = 1'b1;
                state_next = ST_K_RD_A;
            end

            ST_K_RD_A:
            begin
                j_next     = acc_sum;
                si_next    = p_rdata;
                p_re       = 1'b1;
                p_raddr    = acc_sum;
                state_next = ST_K_WR_N;
            end

            ST_K_WR_N:
            begin
                p_we       = 1'b1;
                p_waddr    = i_reg;
                p_wdata    = p_rdata;
                state_next = ST_K_WR_A;
            end

            ST_K_WR_A:
            begin
                p_we    = 1'b1;
                p_waddr = j_reg;
                p_wdata = si_reg;
                i_next  = i_reg + 8'd1;
                kp_next = (kp_inc == key_count_reg) ? '0 : kp_inc;
                state_next = (i_reg == 8'hFF) ? ST_K_DONE : ST_K_RD_N;
            end

            ST_K_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_load            = 1'b1;
                    rsp_data.out_byte   = '0;
                    rsp_data.setup_done = 1'b1;
                    rsp_data.last_out   = 1'b0;
                    j_next              = '0;
                    key_count_next      = '0;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            key_count_reg <= '0;
            kp_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            key_count_reg <= key_count_next;
            kp_reg        <= kp_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        si_reg <= si_next;
        sj_reg <= sj_next;
        if (req_accept)
        begin
            byte_reg <= req.in_byte;
            last_reg <= req.last;
        end
    end

    // ---------------- table storage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pvalid_reg <= '0;
        else if (clr_valid)
            pvalid_reg <= '0;
        else if (p_we)
            pvalid_reg[p_waddr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
            perm_mem[p_waddr] <= p_wdata;
        if (p_re)
        begin
            p_rd_reg  <= perm_mem[p_raddr];
            p_rdv_reg <= pvalid_reg[p_raddr];
            p_rda_reg <= p_raddr;
        end
    end

    // ---------------- key storage ----------------
    always_ff @(posedge clk)
    begin
        if (k_we)
            key_mem[key_count_reg[KIW-1:0]] <= req.in_byte;
        if (k_re)
            key_rd_reg <= key_mem[kp_reg[KIW-1:0]];
    end

    // ---------------- response register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (rsp_load)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
            rsp_reg <= rsp_data;
    end

    // ---------------- checks ----------------
    `RC4_ASSERT_NEXT(a_busy_after_work, req_accept && (req.func == FUNC_DATA || req.last), state_reg != ST_IDLE, "data or last key request did not start the sequencer")
    `RC4_ASSERT_NOW(a_count_bound, 1'b1, key_count_reg <= KCW'(KEY_MAX), "key count beyond store depth")
    `RC4_ASSERT_NOW(a_sched_wrap, state_reg == ST_K_DONE, i_reg == 8'd0 && pvalid_reg != '0, "scheduling ended before 256 steps")
    `RC4_ASSERT_NOW(a_setup_rsp, rsp_valid_reg && rsp_reg.setup_done, rsp_reg.out_byte == 8'd0 && !rsp_reg.last_out, "setup response carries data")

endmodule

// File: tb/rc4_stream_cipher_top_tb.sv
// Self-checking testbench for rc4_stream_cipher_top: keyed RC4 runs with random stalls.
// Depends on rc4_pkg and the rc4_stream_cipher_top RTL.
`timescale 1ns / 1ps

module rc4_stream_cipher_top_tb
    import rc4_pkg::*;
();

    localparam int unsigned KEY_DEPTH    = 512;
    localparam int unsigned ITEM_TARGET  = 1800;
    localparam int unsigned IDLE_PCT     = 31;
    localparam int unsigned REPORT_LIMIT = 10;
    // a last key byte keeps the engine busy through key scheduling
    localparam int unsigned DRAIN_CYCLES = 1100;

    // Tracks the cipher state as seen from the request side and holds the
    // responses still owed by the engine, oldest first.
    class rc4_cipher_tracker;
        logic [7:0]  perm [TABLE_SIZE];
        logic [7:0]  key_bytes [KEY_DEPTH];
        int unsigned key_len;
        logic [7:0]  ptr_i;
        logic [7:0]  ptr_j;
        rc4_rsp_t    pending_rsp [$];
        int unsigned failures;

        function new();
            for (int n = 0; n < TABLE_SIZE; n++)
                perm[n] = 8'(n);
            key_len  = 0;
            ptr_i    = '0;
            ptr_j    = '0;
            failures = 0;
        endfunction

        function void mix_key();
            logic [7:0] acc;
            logic [7:0] tmp;
            acc = '0;
            for (int n = 0; n < TABLE_SIZE; n++)
                perm[n] = 8'(n);
            for (int n = 0; n < TABLE_SIZE; n++)
            begin
                acc       = acc + perm[n] + key_bytes[n % key_len];
                tmp       = perm[n];
                perm[n]   = perm[acc];
                perm[acc] = tmp;
            end
            ptr_i   = '0;
            ptr_j   = '0;
            key_len = 0;
        endfunction

        // Accepted request: update state, queue the response it causes.
        function void note_request(rc4_req_t r);
            rc4_rsp_t   want;
            logic [7:0] si;
            logic [7:0] sj;
            logic [7:0] ks_idx;
            if (r.func == FUNC_KEY)
            begin
                if (key_len < KEY_DEPTH)
                begin
                    key_bytes[key_len] = r.in_byte;
                    key_len++;
                end
                if (!r.last)
                    return;
                mix_key();
                want.out_byte   = '0;
                want.setup_done = 1'b1;
                want.last_out   = 1'b0;
            end
            else
            begin
                ptr_i        = ptr_i + 8'd1;
                ptr_j        = ptr_j + perm[ptr_i];
                si           = perm[ptr_i];
                sj           = perm[ptr_j];
                perm[ptr_i]  = sj;
                perm[ptr_j]  = si;
                ks_idx       = si + sj;
                want.out_byte   = r.in_byte ^ perm[ks_idx];
                want.setup_done = 1'b0;
                want.last_out   = r.last;
            end
            pending_rsp.insert(pending_rsp.size(), want);
        endfunction

        function void flag(string what);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function void check_response(rc4_rsp_t got);
            rc4_rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                flag($sformatf("unexpected response out_byte=%02h setup_done=%0b last_out=%0b",
                               got.out_byte, got.setup_done, got.last_out));
                return;
            end
            want = pending_rsp.pop_front();
            if (got.out_byte !== want.out_byte)
                flag($sformatf("out_byte exp %02h got %02h", want.out_byte, got.out_byte));
            if (got.setup_done !== want.setup_done)
                flag($sformatf("setup_done exp %0b got %0b", want.setup_done, got.setup_done));
            if (got.last_out !== want.last_out)
                flag($sformatf("last_out exp %0b got %0b", want.last_out, got.last_out));
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    rc4_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    rc4_rsp_t rsp;

    // steady: no idling on either side while set
    bit          steady;
    int unsigned sent_count;
    rc4_cipher_tracker tracker = new();

    rc4_stream_cipher_top #(
        .KEY_MAX   (KEY_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, far beyond the length of a normal run.
    initial
    begin
        #20_000_000;
        $display("rc4_stream_cipher_top_tb NOT OK");
        $finish;
    end

    // Response side: random stall, changed only at the falling edge.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_stall = !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Responses are checked at the rising edge, before the engine updates.
    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            tracker.check_response(rsp);

    // Present one request at the falling edge and hold it until it is taken.
    // Valid stays high on return so back-to-back requests need no toggling.
    task automatic send_request(input logic func, input logic [7:0] data, input logic is_last);
        rc4_req_t r;
        r.func    = func;
        r.in_byte = data;
        r.last    = is_last;
        steady    = (sent_count >= 800) && (sent_count < 1100);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req       = r;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        tracker.note_request(r);
        sent_count++;
        @(negedge clk);
    endtask

    // Random key bytes; the final one optionally starts scheduling.
    task automatic send_key(input int unsigned len, input bit with_last);
        for (int unsigned k = 0; k < len; k++)
            send_request(FUNC_KEY, 8'($urandom_range(0, 255)), with_last && (k == len - 1));
    endtask

    // Random data bytes; last marks the end of the run unless scrambled.
    task automatic send_data(input int unsigned len, input bit random_last);
        for (int unsigned k = 0; k < len; k++)
            send_request(FUNC_DATA, 8'($urandom_range(0, 255)),
                         random_last ? 1'($urandom_range(0, 1)) : (k == len - 1));
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned long_keys;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        steady     = 1'b0;
        sent_count = 0;
        long_keys  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Keystream straight out of reset: identity table, zero indices.
        send_request(FUNC_DATA, 8'h00, 1'b0);
        send_request(FUNC_DATA, 8'hFF, 1'b0);
        send_request(FUNC_DATA, 8'h5A, 1'b1);
        // Single-byte key, then extreme data values.
        send_request(FUNC_KEY,  8'hFF, 1'b1);
        send_request(FUNC_DATA, 8'h00, 1'b0);
        send_request(FUNC_DATA, 8'hFF, 1'b0);
        send_request(FUNC_DATA, 8'hA5, 1'b1);
        // Short key with extreme bytes.
        send_request(FUNC_KEY,  8'h00, 1'b0);
        send_request(FUNC_KEY,  8'hFF, 1'b0);
        send_request(FUNC_KEY,  8'h01, 1'b0);
        send_request(FUNC_KEY,  8'h80, 1'b0);
        send_request(FUNC_KEY,  8'h7F, 1'b1);
        send_request(FUNC_DATA, 8'h3C, 1'b0);
        send_request(FUNC_DATA, 8'hC3, 1'b1);
        // Key byte slipped into a data run: generator state must survive
        // until the last-marked key byte arrives.
        send_request(FUNC_KEY,  8'h42, 1'b0);
        send_request(FUNC_DATA, 8'h11, 1'b0);
        send_request(FUNC_DATA, 8'hEE, 1'b1);
        send_request(FUNC_KEY,  8'h99, 1'b1);
        send_request(FUNC_DATA, 8'h00, 1'b0);
        send_request(FUNC_DATA, 8'hFF, 1'b1);

        // Random part: mostly master key + 16 salt bytes then a data run,
        // with scrambled runs, stray key bytes and two oversized keys.
        while (sent_count < ITEM_TARGET)
        begin
            if ((long_keys == 0 && sent_count >= 400) || (long_keys == 1 && sent_count >= 1300))
            begin
                // overflows the key store; extra bytes must be dropped
                send_key($urandom_range(KEY_DEPTH + 1, KEY_DEPTH + 24), 1'b1);
                send_data($urandom_range(4, 30), 1'b0);
                long_keys++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_key($urandom_range(17, 256), 1'b0);
                else
                    send_key($urandom_range(1, 16), 1'b0);
                send_key(16, 1'b1);
                send_data($urandom_range(1, 40), 1'b0);
            end
            else if (pick < 75)
                send_data($urandom_range(1, 20), 1'b1);
            else if (pick < 88)
            begin
                send_data($urandom_range(1, 10), 1'b0);
                send_key($urandom_range(1, 6), 1'b0);
                send_data($urandom_range(1, 10), 1'b0);
                if ($urandom_range(0, 1) == 1)
                    send_key($urandom_range(1, 3), 1'b1);
            end
            else
            begin
                send_key($urandom_range(1, 4), 1'b1);
                send_data($urandom_range(1, 8), 1'b0);
            end
        end
        req_valid = 1'b0;
        steady    = 1'b0;

        while (tracker.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.failures == 0 && tracker.pending_rsp.size() == 0)
            $display("rc4_stream_cipher_top_tb OK");
        else
            $display("rc4_stream_cipher_top_tb NOT OK");
        $finish;
    end

endmodule
